[design/tpsa_pkg.sv]
// shared types and codes for the truncated power series unit
package tpsa_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_NEG = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;
    localparam logic [1:0] ST_OVER = 2'd3;

    typedef struct packed {
        logic load;
        logic start;
        logic mac_rd;
        logic mac_mul;
        logic mac_acc;
        logic div_chk;
        logic div_step;
        logic fin;
        logic emit;
    } tpsa_cmd_t;

    typedef struct packed {
        logic over;
        logic op_mul;
        logic op_div;
        logic b0_zero;
        logic idx_zero;
        logic mac_last;
        logic div_ovf;
        logic div_done;
    } tpsa_sts_t;

endpackage

[design/tpsa_ctrl.sv]
// sequencing state machine for the truncated power series unit
module tpsa_ctrl
    import tpsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  tpsa_sts_t sts,
    output tpsa_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_START   = 8'b0000_0010,
        S_MAC_RD  = 8'b0000_0100,
        S_MAC_MUL = 8'b0000_1000,
        S_MAC_ACC = 8'b0001_0000,
        S_DIV_CHK = 8'b0010_0000,
        S_DIV_RUN = 8'b0100_0000,
        S_FIN_OUT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   fin_done_reg, fin_done_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        fin_done_next = fin_done_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start = 1'b1;
                if (sts.over)
                    state_next = S_FIN_OUT;
                else if (sts.op_mul)
                    state_next = S_MAC_RD;
                else if (sts.op_div && !sts.b0_zero)
                    state_next = sts.idx_zero ? S_DIV_CHK : S_MAC_RD;
                else
                    state_next = S_FIN_OUT;
            end
            S_MAC_RD:
            begin
                cmd.mac_rd = 1'b1;
                state_next = S_MAC_MUL;
            end
            S_MAC_MUL:
            begin
                cmd.mac_mul = 1'b1;
                state_next  = S_MAC_ACC;
            end
            S_MAC_ACC:
            begin
                cmd.mac_acc = 1'b1;
                if (!sts.mac_last)
                    state_next = S_MAC_RD;
                else if (sts.op_div)
                    state_next = S_DIV_CHK;
                else
                    state_next = S_FIN_OUT;
            end
            S_DIV_CHK:
            begin
                cmd.div_chk = 1'b1;
                state_next  = sts.div_ovf ? S_FIN_OUT : S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_FIN_OUT;
            end
            S_FIN_OUT:
            begin
                if (!fin_done_reg)
                begin
                    cmd.fin       = 1'b1;
                    fin_done_next = 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.emit      = 1'b1;
                    fin_done_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                fin_done_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            fin_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fin_done_reg  <= fin_done_next;
        end
    end

endmodule

[design/tpsa_dp.sv]
// datapath: coefficient history, multiply-accumulate, divider and saturation
module tpsa_dp
    import tpsa_pkg::*;
#(
    parameter int MAX_TERMS  = 16,
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tpsa_cmd_t                    cmd,
    output tpsa_sts_t                    sts,
    input  logic [2:0]                   kind,
    input  logic signed [COEF_WIDTH-1:0] a_coef,
    input  logic signed [COEF_WIDTH-1:0] b_coef,
    input  logic                         last,
    output logic signed [COEF_WIDTH-1:0] res_coef,
    output logic [1:0]                   status,
    output logic                         res_last
);

    localparam int CW    = COEF_WIDTH;
    localparam int PW    = 2 * CW;
    localparam int TW    = PW - FRAC_BITS;
    localparam int ACC_W = TW + 8;
    localparam int NW    = ACC_W + FRAC_BITS;
    localparam int IDX_W = $clog2(MAX_TERMS + 1);
    localparam int AW    = $clog2(MAX_TERMS);
    localparam int DCW   = $clog2(CW);

    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [2:0]              op_reg, op_next;
    logic signed [CW-1:0]    a_reg, b_reg, b0_reg;
    logic                    last_reg;
    logic [IDX_W-1:0]        j_reg;
    logic signed [CW-1:0]    a_rd_reg, b_rd_reg, r_rd_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [CW-1:0]           rem_reg, dvd_reg, mag_b0_reg;
    logic                    neg_reg, ovf_reg;
    logic [DCW-1:0]          div_cnt_reg;
    logic signed [CW-1:0]    res_hold_reg, res_out_reg;
    logic [1:0]              st_hold_reg, st_out_reg;
    logic                    last_out_reg;

    logic signed [CW-1:0] a_mem [MAX_TERMS];
    logic signed [CW-1:0] b_mem [MAX_TERMS];
    logic signed [CW-1:0] r_mem [MAX_TERMS];

    logic                    over;
    logic [IDX_W-1:0]        back_idx;
    logic [AW-1:0]           wr_addr, rd_back, rd_fwd;
    logic signed [CW-1:0]    mul_x;
    logic signed [ACC_W-1:0] term;
    logic [ACC_W-1:0]        mag_num;
    logic [NW-1:0]           big_n;
    logic [CW-1:0]           mag_b0;
    logic                    chk_ovf;
    logic [CW:0]             trial;
    logic [CW:0]             trial_diff;
    logic signed [ACC_W-1:0] sat_in;
    logic signed [ACC_W-1:0] q_ext;
    logic signed [CW-1:0]    sat_val;
    logic                    sat_flag;
    logic signed [CW-1:0]    res_val;
    logic [1:0]              st_val;
    logic signed [CW-1:0]    cmax, cmin;

    assign over     = (idx_reg >= IDX_W'(MAX_TERMS));
    assign back_idx = idx_reg - j_reg;
    assign wr_addr  = idx_reg[AW-1:0];
    assign rd_back  = back_idx[AW-1:0];
    assign rd_fwd   = j_reg[AW-1:0];
    assign cmax     = {1'b0, {(CW-1){1'b1}}};
    assign cmin     = {1'b1, {(CW-1){1'b0}}};

    // history memories
    always_ff @(posedge clk)
    begin
        if (cmd.load && !over)
        begin
            a_mem[wr_addr] <= a_coef;
            b_mem[wr_addr] <= b_coef;
        end
        if (cmd.mac_rd)
        begin
            a_rd_reg <= a_mem[rd_back];
            b_rd_reg <= b_mem[rd_fwd];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin && !over)
            r_mem[wr_addr] <= res_val;
        if (cmd.mac_rd)
            r_rd_reg <= r_mem[rd_back];
    end

    // index and operation
    always_comb
    begin
        op_next  = op_reg;
        idx_next = idx_reg;
        if (cmd.load && idx_reg == '0)
            op_next = (kind <= OP_DIV) ? kind : OP_ADD;
        if (cmd.fin)
        begin
            if (!over)
                idx_next = idx_reg + 1'b1;
            if (last_reg)
                idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            op_reg  <= OP_ADD;
        end
        else
        begin
            idx_reg <= idx_next;
            op_reg  <= op_next;
        end
    end

    // multiply-accumulate
    assign mul_x = (op_reg == OP_DIV) ? r_rd_reg : a_rd_reg;
    assign term  = {{(ACC_W-TW){prod_reg[PW-1]}}, prod_reg[PW-1:FRAC_BITS]};

    // divider set-up
    assign mag_num = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign big_n   = {mag_num, {FRAC_BITS{1'b0}}};
    assign mag_b0  = b0_reg[CW-1] ? CW'(-b0_reg) : CW'(b0_reg);
    assign chk_ovf = (big_n[NW-1:CW] >= (NW-CW)'(mag_b0));

    assign trial      = {rem_reg, dvd_reg[CW-1]};
    assign trial_diff = trial - {1'b0, mag_b0_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg    <= a_coef;
            b_reg    <= b_coef;
            last_reg <= last;
            if (idx_reg == '0)
                b0_reg <= b_coef;
        end
        if (cmd.start)
        begin
            j_reg   <= (op_reg == OP_DIV) ? IDX_W'(1) : '0;
            acc_reg <= (op_reg == OP_DIV) ? ACC_W'(a_reg) : '0;
        end
        if (cmd.mac_mul)
            prod_reg <= PW'(mul_x) * PW'(b_rd_reg);
        if (cmd.mac_acc)
        begin
            acc_reg <= (op_reg == OP_DIV) ? acc_reg - term : acc_reg + term;
            j_reg   <= j_reg + 1'b1;
        end
        if (cmd.div_chk)
        begin
            neg_reg     <= acc_reg[ACC_W-1] ^ b0_reg[CW-1];
            ovf_reg     <= chk_ovf;
            mag_b0_reg  <= mag_b0;
            rem_reg     <= big_n[CW +: CW];
            dvd_reg     <= big_n[CW-1:0];
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (!trial_diff[CW])
            begin
                rem_reg <= trial_diff[CW-1:0];
                dvd_reg <= {dvd_reg[CW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[CW-1:0];
                dvd_reg <= {dvd_reg[CW-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // result selection and saturation
    assign q_ext = neg_reg ? -$signed(ACC_W'(dvd_reg)) : $signed(ACC_W'(dvd_reg));

    always_comb
    begin
        case (op_reg)
            OP_SUB:  sat_in = ACC_W'(a_reg) - ACC_W'(b_reg);
            OP_NEG:  sat_in = -ACC_W'(a_reg);
            OP_MUL:  sat_in = acc_reg;
            OP_DIV:  sat_in = q_ext;
            default: sat_in = ACC_W'(a_reg) + ACC_W'(b_reg);
        endcase
    end

    always_comb
    begin
        if (sat_in > ACC_W'(cmax))
        begin
            sat_val  = cmax;
            sat_flag = 1'b1;
        end
        else if (sat_in < ACC_W'(cmin))
        begin
            sat_val  = cmin;
            sat_flag = 1'b1;
        end
        else
        begin
            sat_val  = sat_in[CW-1:0];
            sat_flag = 1'b0;
        end
    end

    always_comb
    begin
        if (over)
        begin
            res_val = '0;
            st_val  = ST_OVER;
        end
        else if (op_reg == OP_DIV && b0_reg == '0)
        begin
            res_val = '0;
            st_val  = ST_DIVZ;
        end
        else if (op_reg == OP_DIV && ovf_reg)
        begin
            res_val = neg_reg ? cmin : cmax;
            st_val  = ST_SAT;
        end
        else
        begin
            res_val = sat_val;
            st_val  = sat_flag ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            res_hold_reg <= res_val;
            st_hold_reg  <= st_val;
        end
        if (cmd.emit)
        begin
            res_out_reg  <= res_hold_reg;
            st_out_reg   <= st_hold_reg;
            last_out_reg <= last_reg;
        end
    end

    assign res_coef = res_out_reg;
    assign status   = st_out_reg;
    assign res_last = last_out_reg;

    assign sts.over     = over;
    assign sts.op_mul   = (op_reg == OP_MUL);
    assign sts.op_div   = (op_reg == OP_DIV);
    assign sts.b0_zero  = (b0_reg == '0);
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.mac_last = (j_reg == idx_reg);
    assign sts.div_ovf  = chk_ovf;
    assign sts.div_done = (div_cnt_reg == DCW'(CW - 1));

endmodule

[design/truncated_power_series_alu_unit.sv]
// top level of the truncated power series arithmetic unit
// one item at a time; a result waiting in the output register does not block the next item
// add, subtract, negate: go from the start state straight to the result stage
// multiply at index i: i+1 terms, one shared multiplier and memory read per term
// divide at index i: i multiply-accumulate terms, then a restoring divider gives one bit per cycle
// reset clears the term index, latched operation and handshake state; history is not cleared
module truncated_power_series_alu_unit
    import tpsa_pkg::*;
#(
    parameter int MAX_TERMS  = 16,
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   kind,
    input  logic signed [COEF_WIDTH-1:0] a_coef,
    input  logic signed [COEF_WIDTH-1:0] b_coef,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COEF_WIDTH-1:0] res_coef,
    output logic [1:0]                   status,
    output logic                         res_last
);

    tpsa_cmd_t cmd;
    tpsa_sts_t sts;

    tpsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tpsa_dp #(
        .MAX_TERMS  (MAX_TERMS),
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .kind     (kind),
        .a_coef   (a_coef),
        .b_coef   (b_coef),
        .last     (last),
        .res_coef (res_coef),
        .status   (status),
        .res_last (res_last)
    );

endmodule
